### src/tbps_pkg.sv
// Shared constants, widths and payload types of the textured Blinn-Phong shading core.
package tbps_pkg;

   localparam int FRAC_BITS = 14;

   localparam int IN_W     = 16;
   localparam int TEX_W    = 8;
   localparam int CFG_W    = 9;
   localparam int NUM_CFG  = 8;
   localparam int ADDR_W   = 5;
   localparam int S_W      = IN_W + 1;
   localparam int SQ_W     = 2 * S_W - 1;
   localparam int LEN2_W   = SQ_W + 1;
   localparam int SQ_STEPS = LEN2_W / 2;
   localparam int ROOT_W   = SQ_STEPS;
   localparam int Q_W      = 2 * FRAC_BITS + 1;
   localparam int MP_W     = S_W + Q_W;
   localparam int H_W      = FRAC_BITS + 3;
   localparam int NH_W     = IN_W + H_W;
   localparam int NDOTH_W  = NH_W + 2;
   localparam int NL_W     = 2 * IN_W;
   localparam int NDOTL_W  = NL_W + 2;
   localparam int D_W      = ((NDOTL_W > 2 * FRAC_BITS + 2) ? NDOTL_W : 2 * FRAC_BITS + 2) + 1;
   localparam int TD_W     = D_W + TEX_W + 1;
   localparam int T_W      = FRAC_BITS + 1;
   localparam int AM_W     = TEX_W + CFG_W;
   localparam int A_W      = AM_W + CFG_W;
   localparam int SP_W     = 2 * CFG_W;
   localparam int C0_W     = SP_W + T_W;
   localparam int TOT_W    = 2 * FRAC_BITS + 26;
   localparam int A_SH     = 2 * FRAC_BITS - 15;
   localparam int C_LSH    = (FRAC_BITS >= 15) ? FRAC_BITS - 15 : 0;
   localparam int C_RSH    = (FRAC_BITS >= 15) ? 0 : 15 - FRAC_BITS;
   localparam int OUT_LSB  = 2 * FRAC_BITS + 1;

   // Front stages, root steps, divider steps, then the eleven back stages.
   localparam int NSTG     = 3 + SQ_STEPS + Q_W + 11;
   localparam int DIV_LAST = 3 + SQ_STEPS + Q_W - 1;
   localparam int H_STG    = DIV_LAST + 2;
   localparam int T_STG    = DIV_LAST + 5;

   localparam logic [T_W-1:0] ONE = T_W'(1) << FRAC_BITS;
   localparam logic signed [TOT_W-1:0] LIM = TOT_W'(255) << OUT_LSB;

   typedef enum logic [2:0] {
      REG_AMB_RED  = 3'd0,
      REG_AMB_GRN  = 3'd1,
      REG_AMB_BLU  = 3'd2,
      REG_AMB_RATE = 3'd3,
      REG_SPC_RED  = 3'd4,
      REG_SPC_GRN  = 3'd5,
      REG_SPC_BLU  = 3'd6,
      REG_SPC_RATE = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [2:0][TEX_W-1:0] tex;
      logic [2:0][S_W-1:0]   s;
      logic [2:0][IN_W-1:0]  n;
      logic [NDOTL_W-1:0]    ndotl;
   } carry_type;

endpackage

### src/textured_blinn_phong_shade_core.sv
// Pipelined textured Blinn-Phong shader with a (1 - N.L) diffuse term and APB registers.
// Stages: 3 front, 17 root steps, 2*FRAC_BITS+1 divider steps, then 11 back stages.
// Throughput: one item per cycle when not stalled; the bit-serial root and reciprocal stages set the depth.
// The whole pipeline holds while a finished item waits at the output register.
// Reset (synchronous, active high) clears all valid bits and loads register defaults.
// Registers need no clearing pass; they are usable in the first cycle after reset.
module textured_blinn_phong_shade_core
   import tbps_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // Fields from bit 0: texel_red, texel_green, texel_blue, light_x, light_y, light_z,
   // view_x, view_y, view_z, normal_x, normal_y, normal_z.
   input  logic [167:0]      req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // Fields from bit 0: out_red, out_green, out_blue.
   output logic [23:0]       rsp_tdata,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   logic adv;
   logic [NSTG-1:0] vld_ff, vld_in;

   // ---------------------------------------------------------------- registers
   logic [CFG_W-1:0] cfg_ff [NUM_CFG];

   assign csr_pready = 1'b1;
   assign csr_prdata = 32'(cfg_ff[csr_paddr[4:2]]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[REG_AMB_RED]  <= 9'd256;
         cfg_ff[REG_AMB_GRN]  <= 9'd256;
         cfg_ff[REG_AMB_BLU]  <= 9'd256;
         cfg_ff[REG_AMB_RATE] <= 9'd0;
         cfg_ff[REG_SPC_RED]  <= 9'd256;
         cfg_ff[REG_SPC_GRN]  <= 9'd256;
         cfg_ff[REG_SPC_BLU]  <= 9'd256;
         cfg_ff[REG_SPC_RATE] <= 9'd0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         cfg_ff[csr_paddr[4:2]] <= csr_pwdata[CFG_W-1:0];
      end
   end

   // ---------------------------------------------------------------- flow control
   assign adv        = !vld_ff[NSTG-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[NSTG-1];
   assign vld_in     = {vld_ff[NSTG-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // ---------------------------------------------------------------- front stages
   carry_type             car0_in, car0_ff, car1_ff, car2_in, car2_ff;
   logic [2:0][IN_W-1:0]  l0_in, l0_ff;
   logic [SQ_W-1:0]       sq1_in [3];
   logic [SQ_W-1:0]       sq1_ff [3];
   logic signed [NL_W-1:0] nl1_in [3];
   logic signed [NL_W-1:0] nl1_ff [3];
   logic [LEN2_W-1:0]     len2_in, len2_ff;

   always_comb begin
      logic [IN_W-1:0] lv, vv;
      logic signed [2*S_W-1:0] sqf;
      car0_in = '0;
      for (int i = 0; i < 3; i++) begin
         car0_in.tex[i] = req_tdata[8*i +: TEX_W];
         lv = req_tdata[24 + 16*i +: IN_W];
         vv = req_tdata[72 + 16*i +: IN_W];
         l0_in[i] = lv;
         car0_in.n[i] = req_tdata[120 + 16*i +: IN_W];
         car0_in.s[i] = S_W'($signed({lv[IN_W-1], lv}) + $signed({vv[IN_W-1], vv}));
      end
      for (int i = 0; i < 3; i++) begin
         sqf = $signed(car0_ff.s[i]) * $signed(car0_ff.s[i]);
         sq1_in[i] = sqf[SQ_W-1:0];
         nl1_in[i] = $signed(car0_ff.n[i]) * $signed(l0_ff[i]);
      end
      len2_in = LEN2_W'(sq1_ff[0]) + LEN2_W'(sq1_ff[1]) + LEN2_W'(sq1_ff[2]);
      car2_in = car1_ff;
      car2_in.ndotl = NDOTL_W'(nl1_ff[0]) + NDOTL_W'(nl1_ff[1]) + NDOTL_W'(nl1_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         car0_ff <= car0_in;
         l0_ff   <= l0_in;
         car1_ff <= car0_ff;
         sq1_ff  <= sq1_in;
         nl1_ff  <= nl1_in;
         car2_ff <= car2_in;
         len2_ff <= len2_in;
      end
   end

   // ---------------------------------------------------------------- square root, one bit pair a stage
   logic [LEN2_W-1:0] sq_rem_ff [SQ_STEPS];
   logic [LEN2_W-1:0] sq_rem_in [SQ_STEPS];
   logic [LEN2_W:0]   sq_res_ff [SQ_STEPS];
   logic [LEN2_W:0]   sq_res_in [SQ_STEPS];
   carry_type         sq_car_ff [SQ_STEPS];
   carry_type         sq_car_in [SQ_STEPS];

   always_comb begin
      logic [LEN2_W-1:0] rem;
      logic [LEN2_W:0]   res, bitv, trial;
      for (int k = 0; k < SQ_STEPS; k++) begin
         rem  = (k == 0) ? len2_ff : sq_rem_ff[(k == 0) ? 0 : k - 1];
         res  = (k == 0) ? '0 : sq_res_ff[(k == 0) ? 0 : k - 1];
         sq_car_in[k] = (k == 0) ? car2_ff : sq_car_ff[(k == 0) ? 0 : k - 1];
         bitv  = (LEN2_W + 1)'(1) << (2 * (SQ_STEPS - 1 - k));
         trial = res + bitv;
         if ({1'b0, rem} >= trial) begin
            sq_rem_in[k] = rem - trial[LEN2_W-1:0];
            sq_res_in[k] = (res >> 1) + bitv;
         end else begin
            sq_rem_in[k] = rem;
            sq_res_in[k] = res >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_rem_ff <= sq_rem_in;
         sq_res_ff <= sq_res_in;
         sq_car_ff <= sq_car_in;
      end
   end

   // ---------------------------------------------------------------- reciprocal 2^(2F)/root, one bit a stage
   logic [ROOT_W-1:0] dv_rem_ff  [Q_W];
   logic [ROOT_W-1:0] dv_rem_in  [Q_W];
   logic [Q_W-1:0]    dv_q_ff    [Q_W];
   logic [Q_W-1:0]    dv_q_in    [Q_W];
   logic [ROOT_W-1:0] dv_root_ff [Q_W];
   logic [ROOT_W-1:0] dv_root_in [Q_W];
   carry_type         dv_car_ff  [Q_W];
   carry_type         dv_car_in  [Q_W];

   always_comb begin
      logic [ROOT_W:0]   trial;
      logic [ROOT_W-1:0] rem;
      logic [Q_W-1:0]    q;
      for (int j = 0; j < Q_W; j++) begin
         if (j == 0) begin
            rem           = '0;
            q             = '0;
            dv_root_in[j] = sq_res_ff[SQ_STEPS-1][ROOT_W-1:0];
            dv_car_in[j]  = sq_car_ff[SQ_STEPS-1];
         end else begin
            rem           = dv_rem_ff[(j == 0) ? 0 : j - 1];
            q             = dv_q_ff[(j == 0) ? 0 : j - 1];
            dv_root_in[j] = dv_root_ff[(j == 0) ? 0 : j - 1];
            dv_car_in[j]  = dv_car_ff[(j == 0) ? 0 : j - 1];
         end
         // The numerator is a single one bit at the top, so only the first step shifts it in.
         trial = {rem, (j == 0) ? 1'b1 : 1'b0};
         if (trial >= {1'b0, dv_root_in[j]}) begin
            dv_rem_in[j] = ROOT_W'(trial - {1'b0, dv_root_in[j]});
            dv_q_in[j]   = {q[Q_W-2:0], 1'b1};
         end else begin
            dv_rem_in[j] = trial[ROOT_W-1:0];
            dv_q_in[j]   = {q[Q_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_rem_ff  <= dv_rem_in;
         dv_q_ff    <= dv_q_in;
         dv_root_ff <= dv_root_in;
         dv_car_ff  <= dv_car_in;
      end
   end

   // ---------------------------------------------------------------- half vector and specular
   logic [MP_W-1:0]           mp_in [3];
   logic [MP_W-1:0]           mp_ff [3];
   logic                      zero_ff;
   carry_type                 m_car_ff, h_car_ff, nh_car_ff, dot_car_ff, t_car_ff;
   logic signed [H_W-1:0]     h_in [3];
   logic signed [H_W-1:0]     h_ff [3];
   logic signed [NH_W-1:0]    nh_in [3];
   logic signed [NH_W-1:0]    nh_ff [3];
   logic signed [NDOTH_W-1:0] ndoth_in, ndoth_ff;
   logic [T_W-1:0]            t_in, t_ff;
   logic [T_W-1:0]            p_in [3];
   logic [T_W-1:0]            p_ff [3];
   carry_type                 p_car_ff [3];

   always_comb begin
      logic [S_W-1:0]          s, mag;
      logic [H_W-2:0]          hm;
      logic [2*T_W-1:0]        pp;
      logic [T_W-1:0]          pprev;
      logic signed [NDOTH_W-1:0] sh;
      for (int i = 0; i < 3; i++) begin
         s   = dv_car_ff[Q_W-1].s[i];
         mag = s[S_W-1] ? S_W'(-s) : s;
         mp_in[i] = MP_W'(mag) * MP_W'(dv_q_ff[Q_W-1]);
      end
      for (int i = 0; i < 3; i++) begin
         hm = mp_ff[i][FRAC_BITS +: H_W-1];
         if (zero_ff) begin
            h_in[i] = '0;
         end else if (m_car_ff.s[i][S_W-1]) begin
            h_in[i] = $signed({1'b0, hm});
         end else begin
            h_in[i] = -$signed({1'b0, hm});
         end
         nh_in[i] = $signed(h_car_ff.n[i]) * h_ff[i];
      end
      ndoth_in = NDOTH_W'(nh_ff[0]) + NDOTH_W'(nh_ff[1]) + NDOTH_W'(nh_ff[2]);
      sh = ndoth_ff >>> FRAC_BITS;
      if (ndoth_ff <= 0) begin
         t_in = '0;
      end else if (sh > $signed(NDOTH_W'(ONE))) begin
         t_in = ONE;
      end else begin
         t_in = sh[T_W-1:0];
      end
      for (int i = 0; i < 3; i++) begin
         pprev   = (i == 0) ? t_ff : p_ff[(i == 0) ? 0 : i - 1];
         pp      = pprev * pprev;
         p_in[i] = pp[FRAC_BITS +: T_W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mp_ff      <= mp_in;
         zero_ff    <= (dv_root_ff[Q_W-1] == '0);
         m_car_ff   <= dv_car_ff[Q_W-1];
         h_ff       <= h_in;
         h_car_ff   <= m_car_ff;
         nh_ff      <= nh_in;
         nh_car_ff  <= h_car_ff;
         ndoth_ff   <= ndoth_in;
         dot_car_ff <= nh_car_ff;
         t_ff       <= t_in;
         t_car_ff   <= dot_car_ff;
         p_ff       <= p_in;
         p_car_ff[0] <= t_car_ff;
         p_car_ff[1] <= p_car_ff[0];
         p_car_ff[2] <= p_car_ff[1];
      end
   end

   // ---------------------------------------------------------------- color combine
   logic [AM_W-1:0]         am_in [3];
   logic [AM_W-1:0]         am_ff [3];
   logic [SP_W-1:0]         sp_in [3];
   logic [SP_W-1:0]         sp_ff [3];
   logic signed [TD_W-1:0]  tda_in [3];
   logic signed [TD_W-1:0]  tda_ff [3];
   logic [T_W-1:0]          pa_ff;
   logic [A_W-1:0]          a_in [3];
   logic [A_W-1:0]          a_ff [3];
   logic [C0_W-1:0]         c0_in [3];
   logic [C0_W-1:0]         c0_ff [3];
   logic signed [TD_W-1:0]  tdb_ff [3];
   logic [2:0][7:0]         out_in, out_ff;

   always_comb begin
      logic signed [D_W-1:0]   dterm;
      logic [TOT_W-1:0]        ash, cfull, cc;
      logic signed [TOT_W-1:0] total;
      dterm = $signed(D_W'(1) << (2 * FRAC_BITS)) - D_W'($signed(p_car_ff[2].ndotl));
      for (int i = 0; i < 3; i++) begin
         am_in[i]  = AM_W'(p_car_ff[2].tex[i]) * AM_W'(cfg_ff[REG_AMB_RED + i]);
         sp_in[i]  = SP_W'(cfg_ff[REG_SPC_RED + i]) * SP_W'(cfg_ff[REG_SPC_RATE]);
         tda_in[i] = $signed({1'b0, p_car_ff[2].tex[i]}) * dterm;
         a_in[i]   = A_W'(am_ff[i]) * A_W'(cfg_ff[REG_AMB_RATE]);
         c0_in[i]  = C0_W'(sp_ff[i]) * C0_W'(pa_ff);
      end
      for (int i = 0; i < 3; i++) begin
         ash   = TOT_W'(a_ff[i]) << A_SH;
         cfull = (TOT_W'(c0_ff[i]) << 8) - TOT_W'(c0_ff[i]);
         cc    = (cfull << C_LSH) >> C_RSH;
         total = $signed(ash) + TOT_W'(tdb_ff[i]) + $signed(cc);
         if (total >= LIM) begin
            out_in[i] = 8'hFF;
         end else if (total <= 0) begin
            out_in[i] = 8'h00;
         end else begin
            out_in[i] = total[OUT_LSB +: 8];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         am_ff  <= am_in;
         sp_ff  <= sp_in;
         tda_ff <= tda_in;
         pa_ff  <= p_ff[2];
         a_ff   <= a_in;
         c0_ff  <= c0_in;
         tdb_ff <= tda_ff;
         out_ff <= out_in;
      end
   end

   assign rsp_tdata = out_ff;

   // ---------------------------------------------------------------- checks
   a_recip_exact: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[DIV_LAST] && dv_root_ff[Q_W-1] != '0) |->
         ((Q_W + ROOT_W)'(dv_q_ff[Q_W-1]) * (Q_W + ROOT_W)'(dv_root_ff[Q_W-1])
            <= ((Q_W + ROOT_W)'(1) << (2 * FRAC_BITS))) &&
         (((Q_W + ROOT_W)'(dv_q_ff[Q_W-1]) + 1) * (Q_W + ROOT_W)'(dv_root_ff[Q_W-1])
            > ((Q_W + ROOT_W)'(1) << (2 * FRAC_BITS))))
      else $error("reciprocal quotient out of bounds");

   a_half_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[H_STG] |->
         (h_ff[0] <= $signed(H_W'(2) << FRAC_BITS)) && (h_ff[0] >= -$signed(H_W'(2) << FRAC_BITS)) &&
         (h_ff[1] <= $signed(H_W'(2) << FRAC_BITS)) && (h_ff[1] >= -$signed(H_W'(2) << FRAC_BITS)) &&
         (h_ff[2] <= $signed(H_W'(2) << FRAC_BITS)) && (h_ff[2] >= -$signed(H_W'(2) << FRAC_BITS)))
      else $error("half vector component too large");

   a_clamp: assert property (@(posedge clock) disable iff (reset)
      vld_ff[T_STG] |-> (t_ff <= ONE))
      else $error("clamped dot product above one");

endmodule
